FILE: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// shared types and constants of the multichannel pulse capture meter
// ----------------------------------------------------------------------------
`default_nettype none

package pmc_pkg;

  typedef enum logic [2:0] {
    ACT_RISE     = 3'd0,
    ACT_FALL     = 3'd1,
    ACT_OVERFLOW = 3'd2,
    ACT_READ     = 3'd3,
    ACT_TMO_READ = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    REG_COUNTS_PER_US   = 2'd0,
    REG_SPEED_SCALE     = 2'd1,
    REG_PERCENT_SCALE   = 2'd2,
    REG_UNDERFLOW_LIMIT = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_TMO,
    S_WALK,
    S_READ,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    J_PER,
    J_HI,
    J_KSPD,
    J_SPD,
    J_DUTY
  } job_t;

  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [14:0] SPEED_MAX = 15'h7FFF;
  localparam logic [15:0] DUTY_MAX  = 16'hFFFF;

  localparam logic [7:0]  CPU_RESET   = 8'd1;
  localparam logic [31:0] SPEED_RESET = 32'd1000000;
  localparam logic [15:0] PCT_RESET   = 16'd10000;
  localparam logic [31:0] UFL_RESET   = 32'h8000_0000;

endpackage

`default_nettype wire

FILE: rtl/pmc_req_if.sv
// ----------------------------------------------------------------------------
// pmc_req_if
// input channel: edge, overflow and read transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface pmc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  channel;
  logic [15:0] capture_value;
  logic [7:0]  pulses_per_rev;
  logic [31:0] timeout_us;

  modport source (output valid, action, channel, capture_value, pulses_per_rev,
                  timeout_us, input ready);
  modport sink (input valid, action, channel, capture_value, pulses_per_rev,
                timeout_us, output ready);
endinterface

`default_nettype wire

FILE: rtl/pmc_rsp_if.sv
// ----------------------------------------------------------------------------
// pmc_rsp_if
// result channel: one transaction per read
// ----------------------------------------------------------------------------
`default_nettype none

interface pmc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] period_us;
  logic [31:0] high_us;
  logic [14:0] speed;
  logic [15:0] duty;
  logic        signal_valid;

  modport source (output valid, period_us, high_us, speed, duty, signal_valid,
                  input ready);
  modport sink (input valid, period_us, high_us, speed, duty, signal_valid,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/multichannel_pulse_capture_meter.sv
// ----------------------------------------------------------------------------
// multichannel_pulse_capture_meter
// period and high time capture on several channels, with a shared divider
// ----------------------------------------------------------------------------
// usage:
//   req carries edge, overflow and read transactions; rsp returns one
//   transaction per read (actions 3 and 4). the user must write registers via
//   cfg_we / cfg_index / cfg_data while the block is idle; it is not enforced.
// timing:
//   rising or falling edge: applied in the EDGE state. timeout write: an
//   extra TMO state before the read. overflow: one channel per cycle
//   through one compare unit. read: a restoring divider shared by all five
//   quotients, one bit a cycle; an invalid channel skips the divider.
//   req.ready is high only between transactions.
// reset:
//   rst clears all channel state, the overflow base and the registers to
//   their defaults; every channel then reads as invalid.
// stall:
//   a result waits in the output register; the next transaction is still
//   taken, and a further read holds before its output until rsp drains.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_pulse_capture_meter #(
  parameter int CHANNELS     = 8,
  parameter int COUNTER_SPAN = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  pmc_req_if.sink                       req,
  pmc_rsp_if.source                     rsp,
  input  wire logic                     cfg_we,
  input  wire pmc_pkg::reg_index_t      cfg_index,
  input  wire logic [31:0]              cfg_data
);
  import pmc_pkg::*;

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state, state_next;
  job_t   job, job_sel;
  logic   job_start;

  logic [7:0]  counts_per_us;
  logic [31:0] speed_scale;
  logic [15:0] percent_scale;
  logic [31:0] underflow_limit;

  logic [31:0] overflow_base;
  logic [31:0] rise_time       [CHANNELS];
  logic [31:0] period_count    [CHANNELS];
  logic [31:0] elapsed_tracker [CHANNELS];
  logic [31:0] high_count      [CHANNELS];
  logic [31:0] timeout_count   [CHANNELS];

  action_t     act;
  logic [IDXW-1:0] ptr;
  logic        ok;
  logic [15:0] cap;
  logic [7:0]  ppr;
  logic [31:0] tmo;

  logic [31:0] r_period, r_high;
  logic [14:0] r_speed;
  logic [15:0] r_duty;
  logic        r_valid;
  logic [47:0] prod;

  logic [47:0] dv_q;
  logic [31:0] dv_rem, dv_den;
  logic [5:0]  dv_cnt;
  logic [32:0] rem_s, rem_sub;
  logic        rem_ge;

  logic [31:0] cur_rt, cur_per, cur_et, cur_hi, cur_tc;
  logic [31:0] now, walk_e;
  logic        chan_live, rd_ok, accept, out_load;
  logic [7:0]  cpu_div;

  assign cur_rt  = rise_time[ptr];
  assign cur_per = period_count[ptr];
  assign cur_et  = elapsed_tracker[ptr];
  assign cur_hi  = high_count[ptr];
  assign cur_tc  = timeout_count[ptr];

  assign now       = overflow_base + {16'd0, cap};
  assign walk_e    = overflow_base - cur_rt;
  assign chan_live = cur_et < cur_tc;
  assign rd_ok     = ok && chan_live;
  assign cpu_div   = (counts_per_us == 8'd0) ? 8'd1 : counts_per_us;

  assign rem_s   = {dv_rem, dv_q[47]};
  assign rem_ge  = rem_s >= {1'b0, dv_den};
  assign rem_sub = rem_s - {1'b0, dv_den};

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_OUT) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_start  = 1'b0;
    job_sel    = J_PER;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (req.action)
            ACT_RISE, ACT_FALL: state_next = S_EDGE;
            ACT_OVERFLOW:       state_next = S_WALK;
            ACT_READ:           state_next = S_READ;
            ACT_TMO_READ:       state_next = S_TMO;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE: state_next = S_IDLE;
      S_TMO:  state_next = S_READ;
      S_WALK: begin
        if (ptr == IDXW'(CHANNELS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (rd_ok) begin
          job_start  = 1'b1;
          job_sel    = J_PER;
          state_next = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (dv_cnt == 6'd0) begin
          unique case (job)
            J_PER: begin
              job_start = 1'b1;
              job_sel   = J_HI;
            end
            J_HI: begin
              if (cur_per == 32'd0) begin
                state_next = S_OUT;
              end else if (ppr == 8'd0) begin
                job_start = 1'b1;
                job_sel   = J_DUTY;
              end else begin
                job_start = 1'b1;
                job_sel   = J_KSPD;
              end
            end
            J_KSPD: begin
              job_start = 1'b1;
              job_sel   = J_SPD;
            end
            J_SPD: begin
              job_start = 1'b1;
              job_sel   = J_DUTY;
            end
            J_DUTY: state_next = S_OUT;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // registers and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_us   <= CPU_RESET;
      speed_scale     <= SPEED_RESET;
      percent_scale   <= PCT_RESET;
      underflow_limit <= UFL_RESET;
      overflow_base   <= 32'd0;
      for (int i = 0; i < CHANNELS; i++) begin
        rise_time[i]       <= 32'd0;
        period_count[i]    <= 32'd0;
        elapsed_tracker[i] <= 32'd0;
        high_count[i]      <= 32'd0;
        timeout_count[i]   <= 32'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COUNTS_PER_US:   counts_per_us   <= cfg_data[7:0];
          REG_SPEED_SCALE:     speed_scale     <= cfg_data;
          REG_PERCENT_SCALE:   percent_scale   <= cfg_data[15:0];
          REG_UNDERFLOW_LIMIT: underflow_limit <= cfg_data;
          default: ;
        endcase
      end
      if (accept && req.action == ACT_OVERFLOW) begin
        overflow_base <= overflow_base + 32'(COUNTER_SPAN);
      end
      if (state == S_EDGE && ok) begin
        if (act == ACT_RISE) begin
          period_count[ptr]    <= now - cur_rt;
          elapsed_tracker[ptr] <= now - cur_rt;
          rise_time[ptr]       <= now;
        end else begin
          high_count[ptr] <= now - cur_rt;
        end
      end
      if (state == S_TMO && ok) begin
        timeout_count[ptr] <= 32'(tmo * {24'd0, counts_per_us});
      end
      if (state == S_WALK && chan_live) begin
        if (walk_e > cur_tc && walk_e < underflow_limit) begin
          elapsed_tracker[ptr] <= cur_tc;
        end else if (walk_e > cur_per && walk_e < underflow_limit) begin
          elapsed_tracker[ptr] <= walk_e;
        end
      end
    end
  end

  // transaction capture, divider and result path
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= action_t'(req.action);
      ok  <= 32'(req.channel) < 32'(CHANNELS);
      ptr <= (req.action == ACT_OVERFLOW) ? '0 : IDXW'(req.channel);
      cap <= req.capture_value;
      ppr <= req.pulses_per_rev;
      tmo <= req.timeout_us;
    end
    if (state == S_WALK) begin
      ptr <= ptr + 1'b1;
    end
    if (state == S_READ) begin
      r_valid  <= rd_ok;
      r_period <= ALL_ONES;
      r_high   <= ALL_ONES;
      r_speed  <= '0;
      r_duty   <= '0;
      prod     <= cur_hi * {16'd0, percent_scale};
    end
    if (state == S_DIV && dv_cnt != 6'd0) begin
      dv_rem <= rem_ge ? rem_sub[31:0] : rem_s[31:0];
      dv_q   <= {dv_q[46:0], rem_ge};
      dv_cnt <= dv_cnt - 6'd1;
    end
    if (state == S_DIV && dv_cnt == 6'd0) begin
      unique case (job)
        J_PER:  r_period <= dv_q[31:0];
        J_HI:   r_high   <= dv_q[31:0];
        J_KSPD: ;
        J_SPD:  r_speed  <= (dv_q > 48'(SPEED_MAX)) ? SPEED_MAX : dv_q[14:0];
        J_DUTY: r_duty   <= (dv_q > 48'(DUTY_MAX)) ? DUTY_MAX : dv_q[15:0];
        default: ;
      endcase
    end
    if (job_start) begin
      job    <= job_sel;
      dv_rem <= 32'd0;
      unique case (job_sel)
        J_PER: begin
          dv_q   <= {cur_per, 16'd0};
          dv_den <= {24'd0, cpu_div};
          dv_cnt <= 6'd32;
        end
        J_HI: begin
          dv_q   <= {cur_hi, 16'd0};
          dv_den <= {24'd0, cpu_div};
          dv_cnt <= 6'd32;
        end
        J_KSPD: begin
          dv_q   <= {speed_scale, 16'd0};
          dv_den <= {24'd0, ppr};
          dv_cnt <= 6'd32;
        end
        J_SPD: begin
          // speed scale over ppr is the quotient just finished
          dv_q   <= {dv_q[31:0], 16'd0};
          dv_den <= cur_per;
          dv_cnt <= 6'd32;
        end
        J_DUTY: begin
          dv_q   <= prod;
          dv_den <= cur_per;
          dv_cnt <= 6'd48;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.period_us    <= r_period;
      rsp.high_us      <= r_high;
      rsp.speed        <= r_speed;
      rsp.duty         <= r_duty;
      rsp.signal_valid <= r_valid;
    end
  end

`ifndef SYNTHESIS
  a_invalid_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.signal_valid |-> rsp.period_us == ALL_ONES &&
      rsp.high_us == ALL_ONES && rsp.speed == '0 && rsp.duty == '0)
    else $error("invalid read result not forced");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && dv_cnt != 6'd0 |-> dv_den != 32'd0)
    else $error("divider running with zero divisor");

  a_base_step: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == ACT_OVERFLOW |=>
      overflow_base == $past(overflow_base) + 32'(COUNTER_SPAN))
    else $error("overflow base not advanced");
`endif

endmodule

`default_nettype wire
